>>> sv/ffdc_pkg.sv
// Shared constants and types for the fixed-frame deframer with checksum.
package ffdc_pkg;

    // Sync, trailer and type codes
    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'h55;
    localparam logic [7:0] TRAILER    = 8'hEE;
    localparam logic [7:0] TYPE_EXT   = 8'h02;

    // Frame geometry: body bytes 2..16 are stored, byte 16 is the checksum
    localparam int unsigned FRAME_LEN   = 18;
    localparam int unsigned BODY_FIRST  = 2;
    localparam int unsigned STORE_DEPTH = 15;
    localparam int unsigned MAX_DLC     = 8;

    // Output field widths and packed tdata width (whole bytes); the
    // extended flag travels on tuser
    localparam int unsigned ID_W       = 32;
    localparam int unsigned LEN_W      = 4;
    localparam int unsigned PAYLOAD_W  = 64;
    localparam int unsigned FIELDS_W   = ID_W + LEN_W + PAYLOAD_W;
    localparam int unsigned OUT_DATA_W = ((FIELDS_W + 7) / 8) * 8;

    // One decoded frame
    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic [LEN_W-1:0]     data_len;
        logic                 ext_flag;
        logic [ID_W-1:0]      frame_id;
    } frame_t;

endpackage

>>> sv/ffdc_parser.sv
// Byte-level frame parser: sync hunt, body capture, running checksum, trailer check.
module ffdc_parser
    import ffdc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,   // a byte transaction is accepted this cycle
    input  logic [7:0] byte_data,
    output logic       frame_valid,  // frame completes with this byte
    output frame_t     frame
);

    typedef enum logic [1:0] {
        HUNT_FIRST  = 2'd0,
        HUNT_SECOND = 2'd1,
        COLLECT     = 2'd2,
        TRAIL       = 2'd3
    } phase_t;

    localparam logic [4:0] CNT_FIRST = 5'(BODY_FIRST);
    localparam logic [4:0] CNT_END   = 5'(BODY_FIRST + STORE_DEPTH);
    localparam logic [4:0] CNT_CHK   = 5'(FRAME_LEN - 2);  // offset of checksum byte

    phase_t     phase_reg, phase_next;
    logic [4:0] count_reg, count_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] store_reg [STORE_DEPTH];

    logic [3:0] wr_idx;
    logic       in_range;
    logic [7:0] dlc;

    assign wr_idx   = 4'(count_reg - CNT_FIRST);
    assign in_range = (count_reg >= CNT_FIRST) && (count_reg < CNT_END);

    // Next phase, count and running sum
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        frame_valid = 1'b0;
        unique case (phase_reg)
            HUNT_FIRST:
            begin
                if (byte_data == HDR_FIRST)
                begin
                    phase_next = HUNT_SECOND;
                end
            end
            HUNT_SECOND:
            begin
                if (byte_data == HDR_SECOND)
                begin
                    count_next = CNT_FIRST;
                    sum_next   = 8'd0;
                    phase_next = COLLECT;
                end
                else if (byte_data != HDR_FIRST)
                begin
                    phase_next = HUNT_FIRST;
                end
            end
            COLLECT:
            begin
                if (in_range)
                begin
                    count_next = count_reg + 5'd1;
                    if (count_reg < CNT_CHK)
                    begin
                        sum_next = sum_reg + byte_data;
                    end
                    if (count_next >= 5'(FRAME_LEN - 1))
                    begin
                        phase_next = TRAIL;
                    end
                end
                else
                begin
                    phase_next = TRAIL;
                end
            end
            TRAIL:
            begin
                frame_valid = (byte_data == TRAILER) &&
                              (sum_reg == store_reg[STORE_DEPTH-1]);
                phase_next  = HUNT_FIRST;
            end
            default:
            begin
                phase_next = HUNT_FIRST;
            end
        endcase
        if (!byte_valid)
        begin
            phase_next  = phase_reg;
            count_next  = count_reg;
            sum_next    = sum_reg;
            frame_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= HUNT_FIRST;
            count_reg <= 5'd0;
            sum_reg   <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    // Body byte store, written at the current offset
    always_ff @(posedge clk)
    begin
        if (byte_valid && phase_reg == COLLECT && in_range)
        begin
            store_reg[wr_idx] <= byte_data;
        end
    end

    // Field extraction from fixed store positions
    assign dlc = store_reg[5];

    always_comb
    begin
        frame.frame_id = {store_reg[1], store_reg[2], store_reg[3], store_reg[4]};
        frame.ext_flag = (store_reg[0] == TYPE_EXT);
        frame.data_len = (dlc > 8'(MAX_DLC)) ? LEN_W'(MAX_DLC) : dlc[LEN_W-1:0];
        for (int k = 0; k < 8; k++)
        begin
            frame.payload[8*k +: 8] = store_reg[6 + k];
        end
    end

endmodule

>>> sv/fixed_frame_deframer_checksum_core.sv
// Top level of the fixed-frame deframer: stream ports and the result register.
//
// Usage:
//   Slave side (s_*) carries received link bytes, one per transaction.
//   The block hunts for 18-byte frames: 0xAA 0x55, type, 32-bit ID
//   (big-endian), DLC, 8 data bytes, 8-bit sum of bytes 2..15, 0xEE.
//   Master side (m_*) carries one transaction per good frame; m_tuser
//   flags an extended ID (type byte 0x02).
// Throughput: one byte per cycle, with no gaps between frames, while s_tready is high.
// Output: the frame appears on m_tvalid in the cycle after its trailer byte
//   is accepted; it is held in a single output register.
// Stall: s_tready stays high while the output register is empty or is
//   being taken in the same cycle; if a frame waits and m_tready is low,
//   s_tready drops for every byte until that frame is taken.
// Reset: rst_n clears the parser to the sync hunt and empties the output
//   register. Frames with a bad checksum or trailer are dropped silently.
module fixed_frame_deframer_checksum_core
    import ffdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [31:0] frame_id, [35:32] data_len,
                                             // [99:36] payload, [103:100] zero
    output logic                  m_tuser    // [0] ext_flag
);

    logic   byte_acc;
    logic   frame_valid;
    frame_t frame;

    logic   out_valid_reg, out_valid_next;
    frame_t out_frame_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign byte_acc = s_tvalid && s_tready;

    ffdc_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_acc),
        .byte_data   (s_tdata),
        .frame_valid (frame_valid),
        .frame       (frame)
    );

    // Output register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (frame_valid)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (frame_valid)
        begin
            out_frame_reg <= frame;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({out_frame_reg.payload, out_frame_reg.data_len,
                                   out_frame_reg.frame_id});
    assign m_tuser  = out_frame_reg.ext_flag;

endmodule

>>> bench/tb_fixed_frame_deframer_checksum_core.sv
// Self-checking testbench for the fixed-frame deframer with checksum.
`timescale 1ns / 100ps

module tb_fixed_frame_deframer_checksum_core;
    import ffdc_pkg::*;

    // Parser phases of the frame predictor
    typedef enum logic [1:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        COLLECT_BODY,
        WAIT_TRAILER
    } parse_state_e;

    // How a generated frame is built
    typedef enum logic [1:0] {
        FRAME_GOOD,
        FRAME_BAD_SUM,
        FRAME_BAD_TRAILER
    } frame_kind_e;

    localparam int unsigned RANDOM_BYTES = 1800;
    localparam int unsigned DRAIN_LIMIT  = 5000;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = 8'h00;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    // Frame predictor state
    parse_state_e parse_state = HUNT_FIRST;
    int unsigned  body_pos    = 0;
    logic [7:0]   body_bytes [STORE_DEPTH];

    // Frames still to come out of the block, oldest first
    frame_t pending_frames [$];

    // Run statistics
    int unsigned fail_count     = 0;
    int unsigned bytes_sent     = 0;
    int unsigned frames_checked = 0;
    int unsigned frames_good    = 0;
    int unsigned frames_bad_sum = 0;
    int unsigned frames_bad_end = 0;

    // Sender burst and receiver stall pattern state
    int unsigned burst_left = 0;
    int unsigned stall_mode = 0;
    int unsigned stall_run  = 0;

    fixed_frame_deframer_checksum_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // Predict the effect of one accepted link byte; returns 1 when a frame completes
    function automatic bit deframe_byte(input logic [7:0] b, output frame_t fr);
        logic [7:0] csum;
        bit         done;
        done = 1'b0;
        fr   = '0;
        case (parse_state)
            HUNT_FIRST:
            begin
                if (b == HDR_FIRST)
                    parse_state = HUNT_SECOND;
            end
            HUNT_SECOND:
            begin
                if (b == HDR_SECOND)
                begin
                    body_pos    = BODY_FIRST;
                    parse_state = COLLECT_BODY;
                end
                else if (b != HDR_FIRST)
                    parse_state = HUNT_FIRST;
            end
            COLLECT_BODY:
            begin
                body_bytes[body_pos - BODY_FIRST] = b;
                body_pos = body_pos + 1;
                if (body_pos >= FRAME_LEN - 1)
                    parse_state = WAIT_TRAILER;
            end
            default:
            begin
                if (b == TRAILER)
                begin
                    csum = 8'h00;
                    for (int k = 0; k < STORE_DEPTH - 1; k++)
                        csum = csum + body_bytes[k];
                    if (csum == body_bytes[STORE_DEPTH - 1])
                    begin
                        fr.frame_id = {body_bytes[1], body_bytes[2],
                                       body_bytes[3], body_bytes[4]};
                        fr.ext_flag = (body_bytes[0] == TYPE_EXT);
                        fr.data_len = (body_bytes[5] > MAX_DLC) ? LEN_W'(MAX_DLC)
                                                                : body_bytes[5][LEN_W-1:0];
                        for (int k = 0; k < 8; k++)
                            fr.payload[8*k +: 8] = body_bytes[6 + k];
                        done = 1'b1;
                    end
                end
                parse_state = HUNT_FIRST;
            end
        endcase
        return done;
    endfunction

    // Random byte that favors the extremes and the sync and trailer codes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return HDR_FIRST;
            3:       return HDR_SECOND;
            4:       return TRAILER;
            default: return 8'($urandom);
        endcase
    endfunction

    // Send one link byte: bursts with random gaps, then wait for the transaction
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        frame_t      fr;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 2);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                s_tdata  <= 8'($urandom);
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent = bytes_sent + 1;
        burst_left = burst_left - 1;
        if (deframe_byte(b, fr))
            pending_frames.push_back(fr);
    endtask

    // Build and send one 18-byte frame, optionally corrupted
    task automatic send_frame(input frame_kind_e kind, input logic [7:0] ftype,
                              input logic [31:0] id, input logic [7:0] dlc,
                              input logic [63:0] data);
        logic [7:0] body [STORE_DEPTH - 1];
        logic [7:0] csum;
        logic [7:0] tail;
        body[0] = ftype;
        for (int k = 0; k < 4; k++)
            body[1 + k] = id[8*(3 - k) +: 8];
        body[5] = dlc;
        for (int k = 0; k < 8; k++)
            body[6 + k] = data[8*k +: 8];
        csum = 8'h00;
        foreach (body[k])
            csum = csum + body[k];
        tail = TRAILER;
        case (kind)
            FRAME_BAD_SUM:
            begin
                csum = csum + 8'($urandom_range(1, 255));
                frames_bad_sum = frames_bad_sum + 1;
            end
            FRAME_BAD_TRAILER:
            begin
                do
                    tail = pick_byte();
                while (tail == TRAILER);
                frames_bad_end = frames_bad_end + 1;
            end
            default:
                frames_good = frames_good + 1;
        endcase
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        foreach (body[k])
            send_byte(body[k]);
        send_byte(csum);
        send_byte(tail);
    endtask

    // Noise in both hunt phases, repeated first sync byte, sync codes and
    // clamped length inside a good frame
    task automatic test_sync_hunt();
        send_byte(8'h00);
        send_byte(HDR_FIRST);
        send_byte(8'h13);
        send_byte(HDR_FIRST);
        send_frame(FRAME_GOOD, TYPE_EXT, 32'hFFFF_FFFF, 8'hFF,
                   64'h7F01_80FF_00EE_55AA);
    endtask

    // Frames with a bad checksum or trailer vanish; the next one gets through
    task automatic test_dropped_frames();
        send_frame(FRAME_BAD_SUM, TYPE_EXT, 32'h1234_5678, 8'h08, 64'hFFFF_FFFF_FFFF_FFFF);
        send_frame(FRAME_BAD_TRAILER, TYPE_EXT, 32'h8765_4321, 8'h04, 64'h0123_4567_89AB_CDEF);
        send_frame(FRAME_GOOD, 8'h00, 32'h0000_0000, 8'h00, 64'h0);
    endtask

    // Mostly well-formed frames with random content, plus noise and broken headers
    task automatic test_random_traffic();
        int unsigned   stop_at;
        int unsigned   sel;
        frame_kind_e   kind;
        logic [7:0]    ftype;
        logic [31:0]   id;
        logic [7:0]    dlc;
        logic [63:0]   data;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 86)
            begin
                kind  = (sel < 70) ? FRAME_GOOD : (sel < 78) ? FRAME_BAD_SUM : FRAME_BAD_TRAILER;
                ftype = ($urandom_range(0, 1) == 0) ? TYPE_EXT : pick_byte();
                case ($urandom_range(0, 5))
                    0:       id = 32'h0000_0000;
                    1:       id = 32'hFFFF_FFFF;
                    default: id = $urandom;
                endcase
                case ($urandom_range(0, 5))
                    0:       dlc = 8'hFF;
                    1:       dlc = 8'($urandom_range(9, 255));
                    default: dlc = 8'($urandom_range(0, 8));
                endcase
                for (int k = 0; k < 8; k++)
                    data[8*k +: 8] = pick_byte();
                send_frame(kind, ftype, id, dlc, data);
            end
            else if (sel < 93)
            begin
                repeat ($urandom_range(1, 5))
                    send_byte(pick_byte());
            end
            else
            begin
                // Header that breaks off after one or more first sync bytes
                repeat ($urandom_range(1, 3))
                    send_byte(HDR_FIRST);
                do
                    ftype = pick_byte();
                while (ftype == HDR_SECOND || ftype == HDR_FIRST);
                send_byte(ftype);
            end
        end
    endtask

    // Result checker and receiver stall pattern
    always @(posedge clk)
    begin
        frame_t got;
        frame_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.frame_id = m_tdata[ID_W-1:0];
            got.data_len = m_tdata[ID_W +: LEN_W];
            got.payload  = m_tdata[ID_W + LEN_W +: PAYLOAD_W];
            got.ext_flag = m_tuser;
            if (pending_frames.size() == 0)
            begin
                $error("unexpected frame: frame_id %h", got.frame_id);
                fail_count = fail_count + 1;
            end
            else
            begin
                want = pending_frames.pop_front();
                frames_checked = frames_checked + 1;
                if (got.frame_id !== want.frame_id)
                begin
                    $error("frame_id: expected %h, actual %h", want.frame_id, got.frame_id);
                    fail_count = fail_count + 1;
                end
                if (got.ext_flag !== want.ext_flag)
                begin
                    $error("ext_flag: expected %b, actual %b",
                           want.ext_flag, got.ext_flag);
                    fail_count = fail_count + 1;
                end
                if (got.data_len !== want.data_len)
                begin
                    $error("data_len: expected %0d, actual %0d", want.data_len, got.data_len);
                    fail_count = fail_count + 1;
                end
                if (got.payload !== want.payload)
                begin
                    $error("payload: expected %h, actual %h", want.payload, got.payload);
                    fail_count = fail_count + 1;
                end
                if (m_tdata[OUT_DATA_W-1:FIELDS_W] !== '0)
                begin
                    $error("tdata padding: expected 0, actual %b",
                           m_tdata[OUT_DATA_W-1:FIELDS_W]);
                    fail_count = fail_count + 1;
                end
            end
        end

        // Stall modes: always ready, coin flip, mostly stalled, long stall blocks
        if (stall_run == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(20, 300);
        end
        else
            stall_run = stall_run - 1;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 5) == 0);
            default: m_tready <= ((stall_run % 32) < 4);
        endcase
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("tb_fixed_frame_deframer_checksum_core failed");
        $finish;
    end

    // Main sequence
    initial
    begin
        int unsigned drain_cycles;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_sync_hunt();
        test_dropped_frames();
        test_random_traffic();

        s_tvalid <= 1'b0;
        drain_cycles = 0;
        while (pending_frames.size() > 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles = drain_cycles + 1;
        end
        repeat (4) @(posedge clk);
        if (pending_frames.size() > 0)
        begin
            $error("%0d expected frames never arrived", pending_frames.size());
            fail_count = fail_count + pending_frames.size();
        end

        $display("Sent %0d link bytes: %0d good frames, %0d with bad checksum,",
                 bytes_sent, frames_good, frames_bad_sum);
        $display("%0d with bad trailer, plus noise and broken headers; %0d frames checked.",
                 frames_bad_end, frames_checked);
        if (fail_count == 0)
            $display("tb_fixed_frame_deframer_checksum_core passed");
        else
            $display("tb_fixed_frame_deframer_checksum_core failed");
        $finish;
    end

endmodule
